### sv/b64_pkg.sv
package b64_pkg;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
    localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SYM_PLUS       = 6'd62;
    localparam logic [5:0] SYM_SLASH      = 6'd63;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef logic [1:0] phase_t;

    localparam phase_t PHASE_0 = 2'd0;
    localparam phase_t PHASE_1 = 2'd1;
    localparam phase_t PHASE_2 = 2'd2;
    localparam phase_t PHASE_3 = 2'd3;

    // One queue entry holds every result that a single input item causes.
    typedef struct packed {
        logic       two;
        logic [7:0] v0;
        logic [7:0] v1;
        logic       bad;
        logic       last;
    } b64_entry_t;

    typedef struct packed {
        logic       bad;
        logic [5:0] val;
    } b64_sym_t;

    function automatic logic [7:0] enc_char(input logic [5:0] idx);
        logic [7:0] c;
        case (idx) inside
            [6'd0:6'd25]:  c = CH_UPPER_A + {2'b00, idx};
            [6'd26:6'd51]: c = CH_LOWER_A + {2'b00, idx - SYM_LOWER_BASE};
            [6'd52:6'd61]: c = CH_DIGIT_0 + {2'b00, idx - SYM_DIGIT_BASE};
            SYM_PLUS:      c = CH_PLUS;
            default:       c = CH_SLASH;
        endcase
        return c;
    endfunction

    function automatic b64_sym_t dec_sym(input logic [7:0] c);
        b64_sym_t s;
        s.bad = 1'b0;
        case (c) inside
            [CH_UPPER_A:CH_UPPER_Z]: s.val = 6'(c - CH_UPPER_A);
            [CH_LOWER_A:CH_LOWER_Z]: s.val = 6'(c - CH_LOWER_A) + SYM_LOWER_BASE;
            [CH_DIGIT_0:CH_DIGIT_9]: s.val = 6'(c - CH_DIGIT_0) + SYM_DIGIT_BASE;
            CH_PLUS:                 s.val = SYM_PLUS;
            CH_SLASH:                s.val = SYM_SLASH;
            default:
            begin
                s.val = 6'd0;
                s.bad = 1'b1;
            end
        endcase
        return s;
    endfunction

endpackage

### sv/b64_in_if.sv
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_value;
    logic       in_last;

    modport source (output valid, output in_value, output in_last, input ready);
    modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

### sv/b64_out_if.sv
interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;
    logic       run_end;
    logic       stream_end;
    logic       bad_symbol;

    modport source (output valid, output out_value, output run_end, output stream_end,
                    output bad_symbol, input ready);
    modport sink   (input valid, input out_value, input run_end, input stream_end,
                    input bad_symbol, output ready);
endinterface

### sv/b64_front.sv
module b64_front (
    input  logic              clk,
    input  logic              rst_n,
    b64_in_if.sink            in_ch,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              q_full,
    output logic              q_push,
    output b64_pkg::b64_entry_t q_data
);
    import b64_pkg::*;

    logic       mode_reg;
    phase_t     phase_reg, phase_next;
    logic [5:0] carry_reg, carry_next;
    logic       carry_bad_reg, carry_bad_next;
    logic       accept;
    logic       produce;
    phase_t     enc_ph;
    b64_sym_t   sym;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign sym         = dec_sym(in_ch.in_value);
    // A phase of three left over from decoding behaves as the start of a group.
    assign enc_ph      = (phase_reg == PHASE_3) ? PHASE_0 : phase_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        carry_next     = carry_reg;
        carry_bad_next = 1'b0;
        produce        = 1'b1;
        q_data.two     = 1'b0;
        q_data.v0      = 8'd0;
        q_data.v1      = 8'd0;
        q_data.bad     = 1'b0;
        q_data.last    = in_ch.in_last;
        if (mode_reg == MODE_ENCODE)
        begin
            case (enc_ph)
                PHASE_0:
                begin
                    q_data.v0  = enc_char(in_ch.in_value[7:2]);
                    carry_next = {in_ch.in_value[1:0], 4'b0000};
                    phase_next = PHASE_1;
                end
                PHASE_1:
                begin
                    q_data.v0  = enc_char(carry_reg | {2'b00, in_ch.in_value[7:4]});
                    carry_next = {in_ch.in_value[3:0], 2'b00};
                    phase_next = PHASE_2;
                end
                default:
                begin
                    q_data.v0  = enc_char(carry_reg | {4'b0000, in_ch.in_value[7:6]});
                    q_data.v1  = enc_char(in_ch.in_value[5:0]);
                    q_data.two = 1'b1;
                    carry_next = 6'd0;
                    phase_next = PHASE_0;
                end
            endcase
            // The final byte of an unfinished group flushes its leftover bits.
            if (in_ch.in_last && phase_next != PHASE_0)
            begin
                q_data.v1  = enc_char(carry_next);
                q_data.two = 1'b1;
            end
        end
        else
        begin
            carry_bad_next = sym.bad;
            q_data.bad     = carry_bad_reg || sym.bad;
            case (phase_reg)
                PHASE_0:
                begin
                    produce    = 1'b0;
                    carry_next = sym.val;
                    phase_next = PHASE_1;
                end
                PHASE_1:
                begin
                    q_data.v0  = {carry_reg, sym.val[5:4]};
                    carry_next = {2'b00, sym.val[3:0]};
                    phase_next = PHASE_2;
                end
                PHASE_2:
                begin
                    q_data.v0  = {carry_reg[3:0], sym.val[5:2]};
                    carry_next = {4'b0000, sym.val[1:0]};
                    phase_next = PHASE_3;
                end
                default:
                begin
                    q_data.v0      = {carry_reg[1:0], sym.val};
                    carry_next     = 6'd0;
                    carry_bad_next = 1'b0;
                    phase_next     = PHASE_0;
                end
            endcase
        end
    end

    assign q_push = accept && produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ENCODE;
            phase_reg     <= PHASE_0;
            carry_reg     <= 6'd0;
            carry_bad_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg      <= cfg_wdata;
            phase_reg     <= PHASE_0;
            carry_reg     <= 6'd0;
            carry_bad_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (in_ch.in_last)
            begin
                phase_reg     <= PHASE_0;
                carry_reg     <= 6'd0;
                carry_bad_reg <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                carry_reg     <= carry_next;
                carry_bad_reg <= carry_bad_next;
            end
        end
    end

    a_lone_char_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_DECODE && phase_reg == PHASE_0 |-> !q_push)
        else $error("decoder produced a byte from the first character of a group");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.in_last |=> phase_reg == PHASE_0 && carry_reg == 6'd0)
        else $error("group state survived the end of a stream");

    a_encode_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_ENCODE && !cfg_we |-> q_push)
        else $error("encoder accepted a byte without producing a character");

endmodule

### sv/b64_queue.sv
module b64_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  b64_pkg::b64_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output b64_pkg::b64_entry_t pop_data
);
    import b64_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    b64_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("item pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond its depth");

endmodule

### sv/b64_back.sv
module b64_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  b64_pkg::b64_entry_t q_data,
    output logic                q_pop,
    b64_out_if.source           out_ch
);
    import b64_pkg::*;

    b64_entry_t cur_reg;
    logic       cur_valid_reg;
    logic       second_reg;
    logic       final_res;
    logic       out_acc;
    logic       load;

    // The second result of an entry is the last one it carries.
    assign final_res = !cur_reg.two || second_reg;
    assign out_acc   = out_ch.valid && out_ch.ready;
    assign load      = !cur_valid_reg || (out_acc && final_res);
    assign q_pop     = load && q_valid;

    assign out_ch.valid      = cur_valid_reg;
    assign out_ch.out_value  = second_reg ? cur_reg.v1 : cur_reg.v0;
    assign out_ch.run_end    = final_res;
    assign out_ch.stream_end = final_res && cur_reg.last;
    assign out_ch.bad_symbol = cur_reg.bad;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else if (load)
        begin
            cur_valid_reg <= q_valid;
            second_reg    <= 1'b0;
        end
        else if (out_acc)
        begin
            second_reg <= 1'b1;
        end
    end

    a_second_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> cur_valid_reg && cur_reg.two)
        else $error("second result shown for an entry that has only one");

endmodule

### sv/base64_unpadded_codec.sv
// A result passes through the entry queue and then the output register.
// One result leaves per cycle while the receiver is ready; an item that
// causes two characters gives them in turn through the single result port.
// Input accepts an item every cycle while the entry queue has room.
// Reset (rst_n, asynchronous, active low) selects encoding and empties the queue.
module base64_unpadded_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    b64_in_if.sink    in_ch,
    b64_out_if.source out_ch,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);
    import b64_pkg::*;

    b64_entry_t push_data;
    b64_entry_t pop_data;
    logic       push;
    logic       full;
    logic       pop;
    logic       pop_valid;

    b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (full),
        .q_push    (push),
        .q_data    (push_data)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    b64_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_data  (pop_data),
        .q_pop   (pop),
        .out_ch  (out_ch)
    );

endmodule

### tb/b64_codec_checker.sv
`timescale 1ns / 100ps

module b64_codec_checker (
    input  logic clk,
    input  logic rst_n,
    b64_in_if    in_mon,
    b64_out_if   out_mon,
    input  logic cfg_we,
    input  logic cfg_wdata,
    output int   fail_count,
    output int   pending
);
    import b64_pkg::*;

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       stream_end;
        logic       bad;
    } codec_result_t;

    codec_result_t predicted_outputs[$];
    logic          mode;
    phase_t        group_phase;
    logic [5:0]    carry_bits;
    logic          carry_bad;

    function automatic logic [7:0] symbol_char(input logic [5:0] idx);
        return ALPHABET[511 - 8 * int'(idx) -: 8];
    endfunction

    function automatic void char_value(input logic [7:0] c, output logic [5:0] val,
                                       output logic bad);
        val = '0;
        bad = 1'b1;
        for (int i = 0; i < 64; i++)
        begin
            if (symbol_char(6'(i)) == c)
            begin
                val = 6'(i);
                bad = 1'b0;
            end
        end
    endfunction

    function automatic codec_result_t make_result(input logic [7:0] v, input logic bad);
        codec_result_t r;
        r.value      = v;
        r.run_end    = 1'b0;
        r.stream_end = 1'b0;
        r.bad        = bad;
        return r;
    endfunction

    function automatic void clear_group();
        group_phase = PHASE_0;
        carry_bits  = '0;
        carry_bad   = 1'b0;
    endfunction

    // Works out the characters or bytes that one accepted item causes.
    task automatic translate_item(input logic [7:0] v, input logic last);
        codec_result_t res [3];
        int            n;
        phase_t        ph;
        logic [5:0]    sym;
        logic          sym_bad;
        logic          prev_bad;
        n = 0;
        if (mode == MODE_ENCODE)
        begin
            // Phase three only exists while decoding; here it counts as a fresh group.
            ph = (group_phase == PHASE_3) ? PHASE_0 : group_phase;
            case (ph)
                PHASE_0:
                begin
                    res[n++]    = make_result(symbol_char(v[7:2]), 1'b0);
                    carry_bits  = {v[1:0], 4'b0000};
                    group_phase = PHASE_1;
                end
                PHASE_1:
                begin
                    res[n++]    = make_result(symbol_char(carry_bits | {2'b00, v[7:4]}), 1'b0);
                    carry_bits  = {v[3:0], 2'b00};
                    group_phase = PHASE_2;
                end
                default:
                begin
                    res[n++]    = make_result(symbol_char(carry_bits | {4'b0000, v[7:6]}),
                                              1'b0);
                    res[n++]    = make_result(symbol_char(v[5:0]), 1'b0);
                    carry_bits  = '0;
                    group_phase = PHASE_0;
                end
            endcase
            if (last && group_phase != PHASE_0)
                res[n++] = make_result(symbol_char(carry_bits), 1'b0);
            carry_bad = 1'b0;
        end
        else
        begin
            char_value(v, sym, sym_bad);
            prev_bad = carry_bad;
            case (group_phase)
                PHASE_0:
                begin
                    carry_bits  = sym;
                    group_phase = PHASE_1;
                end
                PHASE_1:
                begin
                    res[n++]    = make_result({carry_bits, sym[5:4]}, prev_bad | sym_bad);
                    carry_bits  = {2'b00, sym[3:0]};
                    group_phase = PHASE_2;
                end
                PHASE_2:
                begin
                    res[n++]    = make_result({carry_bits[3:0], sym[5:2]}, prev_bad | sym_bad);
                    carry_bits  = {4'b0000, sym[1:0]};
                    group_phase = PHASE_3;
                end
                default:
                begin
                    res[n++]    = make_result({carry_bits[1:0], sym}, prev_bad | sym_bad);
                    carry_bits  = '0;
                    group_phase = PHASE_0;
                end
            endcase
            carry_bad = (group_phase == PHASE_0) ? 1'b0 : sym_bad;
        end
        if (n > 0)
        begin
            res[n - 1].run_end    = 1'b1;
            res[n - 1].stream_end = last;
        end
        for (int i = 0; i < n; i++)
            predicted_outputs.push_back(res[i]);
        if (last)
            clear_group();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        codec_result_t got;
        codec_result_t want;
        if (!rst_n)
        begin
            predicted_outputs.delete();
            mode = MODE_ENCODE;
            clear_group();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got = {out_mon.out_value, out_mon.run_end, out_mon.stream_end,
                       out_mon.bad_symbol};
                if (predicted_outputs.size() == 0)
                begin
                    $error("result %02h arrived with nothing expected", got.value);
                    fail_count++;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("out_value: expected %02h, got %02h", want.value, got.value);
                        fail_count++;
                    end
                    if (got.run_end !== want.run_end)
                    begin
                        $error("run_end: expected %b, got %b", want.run_end, got.run_end);
                        fail_count++;
                    end
                    if (got.stream_end !== want.stream_end)
                    begin
                        $error("stream_end: expected %b, got %b", want.stream_end,
                               got.stream_end);
                        fail_count++;
                    end
                    if (got.bad !== want.bad)
                    begin
                        $error("bad_symbol: expected %b, got %b", want.bad, got.bad);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                mode = cfg_wdata;
                clear_group();
            end
            if (in_mon.valid && in_mon.ready)
                translate_item(in_mon.in_value, in_mon.in_last);
        end
        pending = predicted_outputs.size();
    end

endmodule

### tb/tb_base64_unpadded_codec.sv
`timescale 1ns / 100ps

module tb_base64_unpadded_codec;
    import b64_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 250;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    int   idle_pct;
    int   stall_pct;
    int   fail_count;
    int   pending_count;
    int   cycle_count = 0;
    int   items_sent = 0;

    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;

    b64_in_if  in_ch ();
    b64_out_if out_ch ();

    base64_unpadded_codec uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    b64_codec_checker codec_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver stalls at random, and once holds off for a long stretch.
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready = 1'b0;
        end
        else
            out_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(input logic [7:0] v, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.in_value = v;
        in_ch.in_last  = last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stops offering items until every result is in and the pipeline has emptied.
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input logic m);
        settle();
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mostly alphabet characters, with the odd arbitrary code to exercise bad symbols.
    function automatic logic [7:0] pick_char();
        int k;
        k = $urandom_range(99);
        if (k < 8)
            return 8'($urandom_range(255));
        k = $urandom_range(63);
        if (k < 26)
            return CH_UPPER_A + 8'(k);
        else if (k < 52)
            return CH_LOWER_A + 8'(k - 26);
        else if (k < 62)
            return CH_DIGIT_0 + 8'(k - 52);
        else if (k == 62)
            return CH_PLUS;
        return CH_SLASH;
    endfunction

    task automatic run_segment(input logic m, input int budget);
        int   start;
        int   n;
        logic open_end;
        start = items_sent;
        set_mode(m);
        while (items_sent - start < budget)
        begin
            n        = $urandom_range(1, 12);
            open_end = ($urandom_range(99) < 10);
            for (int i = 0; i < n; i++)
                send_item((m == MODE_ENCODE) ? 8'($urandom_range(255)) : pick_char(),
                          !open_end && (i == n - 1));
        end
    endtask

    initial
    begin
        logic m;
        int   target;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = MODE_ENCODE;
        in_ch.valid    = 1'b0;
        in_ch.in_value = '0;
        in_ch.in_last  = 1'b0;
        out_ch.ready   = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Encoding: a whole group with no tail, then one- and two-byte tails.
        set_mode(MODE_ENCODE);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'hAA, 1'b0);
        send_item(8'h55, 1'b1);

        // Decoding: the alphabet's edges, then a bad character opening a group.
        set_mode(MODE_DECODE);
        send_item("A", 1'b0);
        send_item("z", 1'b0);
        send_item("0", 1'b0);
        send_item("/", 1'b0);
        send_item(8'h40, 1'b0);
        send_item("+", 1'b0);
        send_item("9", 1'b0);
        send_item("Z", 1'b0);
        // A lone bad character at the end of a stream produces nothing at all.
        send_item(8'h7B, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        // Five characters leave a lone trailing character after a full group.
        send_item("a", 1'b0);
        send_item("b", 1'b0);
        send_item("c", 1'b0);
        send_item("d", 1'b0);
        send_item("e", 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 80; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 8;  stall_pct = 8;  end
            endcase
            if (p == 0)
            begin
                // Hold the output back while items keep coming, so the input backs up.
                set_mode(MODE_ENCODE);
                @(posedge clk);
                hold_req = 1'b1;
                for (int i = 0; i < 30; i++)
                    send_item(8'($urandom_range(255)), i == 29);
                settle();
            end
            target = items_sent + PHASE_ITEMS;
            m      = 1'($urandom_range(1));
            while (items_sent < target)
            begin
                run_segment(m, $urandom_range(30, 70));
                m = ~m;
            end
        end

        settle();
        if (fail_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
sv/b64_pkg.sv
sv/b64_in_if.sv
sv/b64_out_if.sv
sv/b64_front.sv
sv/b64_queue.sv
sv/b64_back.sv
sv/base64_unpadded_codec.sv
tb/b64_codec_checker.sv
tb/tb_base64_unpadded_codec.sv
